@@ src/hvn2d_pkg.sv @@
// Shared constants for the hashed 2D value noise core.
package hvn2d_pkg;

    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned COORD_WIDTH_DEF = 32;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned NOISE_W  = 24;
    localparam int unsigned CORNERS  = 4;

    localparam logic [HASH_W-1:0] HASH_K_X  = 32'd374761393;
    localparam logic [HASH_W-1:0] HASH_K_Y  = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_K_XY = HASH_K_X + HASH_K_Y;
    localparam logic [HASH_W-1:0] MIX_C1    = 32'h7feb352d;
    localparam logic [HASH_W-1:0] MIX_C2    = 32'h846ca68b;

endpackage

@@ src/hvn2d_ease.sv @@
// Two-stage smoothstep easing of a lattice fraction.
module hvn2d_ease #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [FRAC_BITS-1:0] eased
);

    localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS+2)'(3) << FRAC_BITS;

    logic [2*FRAC_BITS-1:0] sq;
    logic [FRAC_BITS-1:0]   f2_reg;
    logic [FRAC_BITS-1:0]   f2_next;
    logic [FRAC_BITS+1:0]   t_reg;
    logic [FRAC_BITS+1:0]   t_next;
    logic [2*FRAC_BITS+1:0] prod;
    logic [FRAC_BITS-1:0]   eased_reg;
    logic [FRAC_BITS-1:0]   eased_next;

    always_comb
    begin
        sq         = frac * frac;
        f2_next    = sq[2*FRAC_BITS-1:FRAC_BITS];
        t_next     = THREE_ONE - {1'b0, frac, 1'b0};
        prod       = f2_reg * t_reg;
        eased_next = prod[2*FRAC_BITS-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        f2_reg    <= f2_next;
        t_reg     <= t_next;
        eased_reg <= eased_next;
    end

    assign eased = eased_reg;

endmodule

@@ src/hvn2d_hash.sv @@
// Five-stage pipeline hashing the four corner cells to 24-bit values.
module hvn2d_hash
    import hvn2d_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [HASH_W-1:0]                cell_x,
    input  logic [HASH_W-1:0]                cell_y,
    output logic                             out_valid,
    output logic [CORNERS-1:0][NOISE_W-1:0]  corner
);

    localparam logic [HASH_W-1:0] OFFS [CORNERS] = '{'0, HASH_K_X, HASH_K_Y, HASH_K_XY};

    logic [4:0]              vld_reg;
    logic [HASH_W-1:0]       a_reg, a_next, b_reg, b_next;
    logic [HASH_W-1:0]       base;
    logic [HASH_W-1:0]       sum_w   [CORNERS];
    logic [HASH_W-1:0]       mix_w   [CORNERS];
    logic [HASH_W-1:0]       fin_w   [CORNERS];
    logic [HASH_W-1:0]       h1_reg  [CORNERS];
    logic [HASH_W-1:0]       h1_next [CORNERS];
    logic [HASH_W-1:0]       h2_reg  [CORNERS];
    logic [HASH_W-1:0]       h2_next [CORNERS];
    logic [HASH_W-1:0]       h3_reg  [CORNERS];
    logic [HASH_W-1:0]       h3_next [CORNERS];
    logic [CORNERS-1:0][NOISE_W-1:0] corner_reg, corner_next;

    always_comb
    begin
        a_next = cell_x * HASH_K_X;
        b_next = cell_y * HASH_K_Y;
        base   = a_reg + b_reg;
        for (int i = 0; i < CORNERS; i++)
        begin
            sum_w[i]       = base + OFFS[i];
            h1_next[i]     = sum_w[i] ^ (sum_w[i] >> 16);
            h2_next[i]     = h1_reg[i] * MIX_C1;
            mix_w[i]       = h2_reg[i] ^ (h2_reg[i] >> 15);
            h3_next[i]     = mix_w[i] * MIX_C2;
            fin_w[i]       = h3_reg[i] ^ (h3_reg[i] >> 16);
            corner_next[i] = fin_w[i][NOISE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        for (int i = 0; i < CORNERS; i++)
        begin
            if (vld_reg[0])
            begin
                h1_reg[i] <= h1_next[i];
            end
            if (vld_reg[1])
            begin
                h2_reg[i] <= h2_next[i];
            end
            if (vld_reg[2])
            begin
                h3_reg[i] <= h3_next[i];
            end
        end
        if (vld_reg[3])
        begin
            corner_reg <= corner_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign corner    = corner_reg;

`ifndef SYNTH
    a_hash_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 5))
        else $error("hash word without matching input");
`endif

endmodule

@@ src/hvn2d_blend.sv @@
// Registered linear blend of two noise values by an eased weight.
module hvn2d_blend
    import hvn2d_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NOISE_W-1:0]   p,
    input  logic [NOISE_W-1:0]   q,
    input  logic [FRAC_BITS-1:0] w,
    output logic                 out_valid,
    output logic [NOISE_W-1:0]   res
);

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [FRAC_BITS:0]           inv;
    logic [NOISE_W+FRAC_BITS:0]   acc;
    logic [NOISE_W-1:0]           res_reg, res_next;
    logic                         valid_reg;

    always_comb
    begin
        inv      = ONE - {1'b0, w};
        acc      = p * inv + q * w;
        res_next = acc[FRAC_BITS+NOISE_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

`ifndef SYNTH
    a_blend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((res_reg >= $past(p) || res_reg >= $past(q)) &&
                       (res_reg <= $past(p) || res_reg <= $past(q))))
        else $error("blend word outside its end points");
`endif

endmodule

@@ src/hashed_value_noise_2d_core.sv @@
// Top level of the hashed 2D value noise core: split, hash, ease and blend.
// An accepted start reaches the done strobe through the hash stages, the edge blends and the final blend.
// Throughput: one word per cycle; busy stays low, so start may be high every cycle.
// The depth is set by the hash chain (two products, then two mixing products).
// Reset clears the valid pipeline only; words in flight are dropped.
module hashed_value_noise_2d_core
    import hvn2d_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] x_pos,
    input  logic signed [COORD_WIDTH-1:0] y_pos,
    output logic                          done,
    output logic [NOISE_W-1:0]            noise_value
);

    localparam int unsigned CELL_W = COORD_WIDTH - FRAC_BITS;
    localparam int unsigned U_DLY  = 3;
    localparam int unsigned V_DLY  = 4;

    logic                            accept;
    logic [HASH_W-1:0]               cell_x, cell_y;
    logic [FRAC_BITS-1:0]            u_ease, v_ease;
    logic [FRAC_BITS-1:0]            u_dly_reg [U_DLY];
    logic [FRAC_BITS-1:0]            v_dly_reg [V_DLY];
    logic                            corner_valid;
    logic [CORNERS-1:0][NOISE_W-1:0] corner;
    logic                            edge_valid;
    logic [NOISE_W-1:0]              top_val, bot_val;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    generate
        if (CELL_W >= HASH_W)
        begin : g_wide_cell
            assign cell_x = x_pos[FRAC_BITS+HASH_W-1:FRAC_BITS];
            assign cell_y = y_pos[FRAC_BITS+HASH_W-1:FRAC_BITS];
        end
        else
        begin : g_narrow_cell
            assign cell_x = {{(HASH_W-CELL_W){x_pos[COORD_WIDTH-1]}},
                             x_pos[COORD_WIDTH-1:FRAC_BITS]};
            assign cell_y = {{(HASH_W-CELL_W){y_pos[COORD_WIDTH-1]}},
                             y_pos[COORD_WIDTH-1:FRAC_BITS]};
        end
    endgenerate

    hvn2d_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .out_valid (corner_valid),
        .corner    (corner)
    );

    hvn2d_ease #(.FRAC_BITS(FRAC_BITS)) u_ease_x (
        .clk   (clk),
        .frac  (x_pos[FRAC_BITS-1:0]),
        .eased (u_ease)
    );

    hvn2d_ease #(.FRAC_BITS(FRAC_BITS)) u_ease_y (
        .clk   (clk),
        .frac  (y_pos[FRAC_BITS-1:0]),
        .eased (v_ease)
    );

    // align the eased weights with the corner values
    always_ff @(posedge clk)
    begin
        u_dly_reg[0] <= u_ease;
        for (int i = 1; i < U_DLY; i++)
        begin
            u_dly_reg[i] <= u_dly_reg[i-1];
        end
        v_dly_reg[0] <= v_ease;
        for (int i = 1; i < V_DLY; i++)
        begin
            v_dly_reg[i] <= v_dly_reg[i-1];
        end
    end

    hvn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (corner_valid),
        .p         (corner[0]),
        .q         (corner[1]),
        .w         (u_dly_reg[U_DLY-1]),
        .out_valid (edge_valid),
        .res       (top_val)
    );

    hvn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_bot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (corner_valid),
        .p         (corner[2]),
        .q         (corner[3]),
        .w         (u_dly_reg[U_DLY-1]),
        .out_valid (),
        .res       (bot_val)
    );

    hvn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (edge_valid),
        .p         (top_val),
        .q         (bot_val),
        .w         (v_dly_reg[V_DLY-1]),
        .out_valid (done),
        .res       (noise_value)
    );

`ifndef SYNTH
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result word without accepted start");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the hashed 2D value noise core.
`timescale 1ns / 1ps

module testbench;
    import hvn2d_pkg::*;

    localparam int unsigned FB        = FRAC_BITS_DEF;
    localparam int unsigned CW        = COORD_WIDTH_DEF;
    localparam logic [63:0] ONE_FX    = 64'd1 << FB;
    localparam int unsigned N_RANDOM  = 400;
    localparam int unsigned MAX_LINES = 20;
    localparam longint      CYCLE_CAP = 200000;

    class noise_scoreboard;
        logic [NOISE_W-1:0] pending[$];
        int                 errors = 0;

        function automatic logic [NOISE_W-1:0] corner_hash(logic [31:0] cx, logic [31:0] cy);
            logic [31:0] h;
            h = cx * HASH_K_X + cy * HASH_K_Y;
            h = h ^ (h >> 16);
            h = h * MIX_C1;
            h = h ^ (h >> 15);
            h = h * MIX_C2;
            h = h ^ (h >> 16);
            return h[NOISE_W-1:0];
        endfunction

        function automatic logic [63:0] ease_frac(logic [63:0] f);
            logic [63:0] f2;
            f2 = (f * f) >> FB;
            return (f2 * (3 * ONE_FX - 2 * f)) >> FB;
        endfunction

        function automatic logic [63:0] blend_fx(logic [63:0] p, logic [63:0] q,
                                                 logic [63:0] w);
            return (p * (ONE_FX - w) + q * w) >> FB;
        endfunction

        function automatic logic [NOISE_W-1:0] noise_at(logic [CW-1:0] xr, logic [CW-1:0] yr);
            logic signed [CW-1:0] sx;
            logic signed [CW-1:0] sy;
            logic [31:0]          cx;
            logic [31:0]          cy;
            logic [63:0]          u;
            logic [63:0]          v;
            logic [63:0]          top;
            logic [63:0]          bot;
            logic [63:0]          mixed;
            sx    = xr;
            sy    = yr;
            cx    = sx >>> FB;
            cy    = sy >>> FB;
            u     = ease_frac({{(64-FB){1'b0}}, xr[FB-1:0]});
            v     = ease_frac({{(64-FB){1'b0}}, yr[FB-1:0]});
            top   = blend_fx(corner_hash(cx, cy), corner_hash(cx + 32'd1, cy), u);
            bot   = blend_fx(corner_hash(cx, cy + 32'd1),
                             corner_hash(cx + 32'd1, cy + 32'd1), u);
            mixed = blend_fx(top, bot, v);
            return mixed[NOISE_W-1:0];
        endfunction

        function void note_point(logic [CW-1:0] xr, logic [CW-1:0] yr);
            pending.push_back(noise_at(xr, yr));
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_LINES)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_noise(logic [NOISE_W-1:0] got);
            logic [NOISE_W-1:0] want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("noise_value %06h with no word pending", got));
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("noise_value %06h, want %06h", got, want));
            end
        endtask
    endclass

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic signed [CW-1:0] x_pos = '0;
    logic signed [CW-1:0] y_pos = '0;
    logic                 busy;
    logic                 done;
    logic [NOISE_W-1:0]   noise_value;
    longint               cycles = 0;

    noise_scoreboard sb = new;

    hashed_value_noise_2d_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .done        (done),
        .noise_value (noise_value)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_point(x_pos, y_pos);
            if (done)
                sb.check_noise(noise_value);
        end
    end

    task automatic send_word(logic [CW-1:0] xv, logic [CW-1:0] yv);
        start <= 1'b1;
        x_pos <= xv;
        y_pos <= yv;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        logic [CW-1:0] c;
        c = $urandom;
        case ($urandom_range(0, 9))
            4, 5:    c = $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
            6:       c[FB-1:0] = ($urandom_range(0, 1) != 0) ? '1 : FB'($urandom_range(0, 1));
            7:       c[CW-1:FB] = ($urandom_range(0, 1) != 0) ? '1 : '0;
            8:       c[CW-1:CW-2] = ($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10;
            default: ;
        endcase
        return c;
    endfunction

    logic [CW-1:0] corner_x[14] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_8000, 32'h0000_8000,
        32'h0001_0000, 32'hFFFE_0001, 32'h1234_5678, 32'h0000_0001
    };
    logic [CW-1:0] corner_y[14] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_4000, 32'h0000_8000,
        32'h0002_0000, 32'h7FFF_0001, 32'hFEDC_BA98, 32'hFFFF_FFFE
    };

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 14; i++)
        begin
            send_word(corner_x[i], corner_y[i]);
            hold_off((i % 4 == 3) ? pick_gap() : 0);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            send_word(pick_coord(), pick_coord());
            if (i == N_RANDOM / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            else if (i < 60 || i > 120)
            begin
                hold_off(pick_gap());
            end
        end

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
